// ===== hdl/mf5_pkg.sv =====
package mf5_pkg;

  // defaults for the top-level parameters
  localparam int DEFAULT_MAX_WIDTH  = 2048;
  localparam int DEFAULT_PIXEL_BITS = 16;

  // window geometry
  localparam int WIN      = 5;
  localparam int WIN_AREA = WIN * WIN;
  localparam int MED_RANK = 13;
  localparam int LINES    = WIN - 1;
  localparam int BORDER   = 2;

  // fixed field widths
  localparam int CFG_BITS = 12;
  localparam int X_BITS   = 11;
  localparam int Y_BITS   = 12;

  localparam logic [CFG_BITS-1:0] WIDTH_RESET = 12'd640;

  // centre coordinates travelling with a window
  typedef struct packed {
    logic [X_BITS-1:0] x;
    logic [Y_BITS-1:0] y;
  } coord_t;

endpackage

// ===== hdl/mf5_ram.sv =====
module mf5_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/mf5_median_sel.sv =====
module mf5_median_sel #(
  parameter int PIXEL_BITS = mf5_pkg::DEFAULT_PIXEL_BITS
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            en,
  input  logic                                            in_valid,
  input  logic [mf5_pkg::WIN_AREA-1:0][PIXEL_BITS-1:0]    win,
  input  mf5_pkg::coord_t                                 in_coord,
  output logic                                            out_valid,
  output logic [PIXEL_BITS-1:0]                           median,
  output mf5_pkg::coord_t                                 out_coord
);

  localparam int N  = mf5_pkg::WIN_AREA;
  localparam int RB = $clog2(N);

  logic                       b_valid;
  logic [N-1:0]               b_before [N];
  logic [N-1:0]               before_comb [N];
  logic [N-1:0][PIXEL_BITS-1:0] b_vals;
  mf5_pkg::coord_t            b_coord;

  logic                       c_valid;
  logic [RB-1:0]              c_rank [N];
  logic [RB-1:0]              rank_comb [N];
  logic [N-1:0][PIXEL_BITS-1:0] c_vals;
  mf5_pkg::coord_t            c_coord;

  logic [PIXEL_BITS-1:0]      sel_comb;

  // order every pair, ties broken by position so ranks are distinct
  always_comb begin
    for (int i = 0; i < N; i++) begin
      for (int j = 0; j < N; j++) begin
        if (i == j) begin
          before_comb[i][j] = 1'b0;
        end else if (i < j) begin
          before_comb[i][j] = $signed(win[i]) <= $signed(win[j]);
        end else begin
          before_comb[i][j] = $signed(win[i]) < $signed(win[j]);
        end
      end
    end
  end

  // count predecessors of each element
  always_comb begin
    for (int j = 0; j < N; j++) begin
      rank_comb[j] = '0;
      for (int i = 0; i < N; i++) begin
        rank_comb[j] = rank_comb[j] + RB'(b_before[i][j]);
      end
    end
  end

  // pick the element whose rank is the median rank
  always_comb begin
    sel_comb = '0;
    for (int j = 0; j < N; j++) begin
      if (c_rank[j] == RB'(mf5_pkg::MED_RANK - 1)) begin
        sel_comb = sel_comb | c_vals[j];
      end
    end
  end

  // hold valid flags across stalls
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      b_valid   <= in_valid;
      c_valid   <= b_valid;
      out_valid <= c_valid;
    end
  end

  // advance payload stages
  always_ff @(posedge clk) begin
    if (en) begin
      b_before  <= before_comb;
      b_vals    <= win;
      b_coord   <= in_coord;
      c_rank    <= rank_comb;
      c_vals    <= b_vals;
      c_coord   <= b_coord;
      median    <= sel_comb;
      out_coord <= c_coord;
    end
  end

endmodule

// ===== hdl/median_filter_5x5_unit.sv =====
// 5x5 median filter on a raster pixel stream. One pixel is taken per clock
// cycle; a result held by out_stall stalls the input side in the same cycle.
// Each median passes the stage 1, window, pair, rank and output registers.
// The rate is set by the line store: one RAM word per column holds the four
// previous rows, read when a pixel is taken and written back from stage 1,
// with the write data forwarded when two consecutive pixels land on the same
// column. Pixels in the two-pixel border give no result; centre coordinates
// come with each median. Line contents are not cleared after reset, and no
// result ever uses an entry not written in the current frame. The user must
// write image_width only when idle; the block does not enforce it.
module median_filter_5x5_unit #(
  parameter int MAX_WIDTH  = mf5_pkg::DEFAULT_MAX_WIDTH,
  parameter int PIXEL_BITS = mf5_pkg::DEFAULT_PIXEL_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [mf5_pkg::CFG_BITS-1:0]  cfg_wr_data,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [PIXEL_BITS-1:0]         pixel,
  input  logic                          frame_start,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [PIXEL_BITS-1:0]         median,
  output logic [mf5_pkg::X_BITS-1:0]    center_x,
  output logic [mf5_pkg::Y_BITS-1:0]    center_y
);

  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int WB    = (CW + 1 > mf5_pkg::CFG_BITS) ? CW + 1 : mf5_pkg::CFG_BITS;
  localparam int LN    = mf5_pkg::LINES;
  localparam int WN    = mf5_pkg::WIN;
  localparam int YB    = mf5_pkg::Y_BITS;

  logic [mf5_pkg::CFG_BITS-1:0] image_width;
  logic [CW-1:0]                column_count;
  logic [YB-1:0]                row_count;

  logic                         adv;
  logic                         accept;
  logic [CW-1:0]                col_cur;
  logic [YB-1:0]                row_cur;
  logic [WB-1:0]                width_eff;
  logic                         row_end;
  logic                         emit_cur;

  logic                         s1_valid;
  logic [CW-1:0]                s1_col;
  logic [YB-1:0]                s1_row;
  logic [PIXEL_BITS-1:0]        s1_pixel;
  logic                         s1_emit;
  logic                         s1_fwd;
  logic [LN-1:0][PIXEL_BITS-1:0] fwd_data;
  logic [LN-1:0][PIXEL_BITS-1:0] rd_data;
  logic [LN-1:0][PIXEL_BITS-1:0] line_cur;
  logic [LN-1:0][PIXEL_BITS-1:0] wr_data;
  logic                         wr_en;

  logic [PIXEL_BITS-1:0]        win [WN][WN];
  logic [mf5_pkg::WIN_AREA-1:0][PIXEL_BITS-1:0] win_flat;

  logic                         a_valid;
  mf5_pkg::coord_t              a_coord;
  mf5_pkg::coord_t              s1_coord;
  mf5_pkg::coord_t              out_coord;
  logic [CW-1:0]                col_m2;

  // pipeline moves unless a finished result is held up
  assign adv      = !out_valid || !out_stall;
  assign accept   = in_valid && adv;
  assign in_stall = !adv;

  // position of the incoming pixel
  assign col_cur   = frame_start ? '0 : column_count;
  assign row_cur   = frame_start ? '0 : row_count;
  assign width_eff = (WB'(image_width) > WB'(MAX_WIDTH)) ? WB'(MAX_WIDTH) : WB'(image_width);
  assign row_end   = (WB'(col_cur) + WB'(1)) >= width_eff;
  assign emit_cur  = (col_cur >= CW'(WN - 1)) && (row_cur >= YB'(WN - 1));

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= mf5_pkg::WIDTH_RESET;
    end else if (cfg_wr_en) begin
      image_width <= cfg_wr_data;
    end
  end

  // advance column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_end) begin
        column_count <= '0;
        row_count    <= row_cur + YB'(1);
      end else begin
        column_count <= col_cur + CW'(1);
        row_count    <= row_cur;
      end
    end
  end

  // line store: four rows per column word
  mf5_ram #(
    .WIDTH(LN * PIXEL_BITS),
    .DEPTH(MAX_WIDTH)
  ) u_line_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_col),
    .wr_data(wr_data),
    .rd_en  (accept),
    .rd_addr(col_cur),
    .rd_data(rd_data)
  );

  // stage 1 control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept;
    end
  end

  // stage 1 payload; note a write landing on the column being read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col   <= col_cur;
      s1_row   <= row_cur;
      s1_pixel <= pixel;
      s1_emit  <= emit_cur;
      s1_fwd   <= s1_valid && (s1_col == col_cur);
      fwd_data <= wr_data;
    end
  end

  // take forwarded lines, drop the oldest, push the new pixel
  assign line_cur = s1_fwd ? fwd_data : rd_data;
  assign wr_en    = s1_valid && adv;

  always_comb begin
    for (int r = 0; r < LN - 1; r++) begin
      wr_data[r] = line_cur[r + 1];
    end
    wr_data[LN - 1] = s1_pixel;
  end

  // shift the window left and load the new column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int r = 0; r < WN; r++) begin
        for (int c = 0; c < WN - 1; c++) begin
          win[r][c] <= win[r][c + 1];
        end
      end
      for (int r = 0; r < LN; r++) begin
        win[r][WN - 1] <= line_cur[r];
      end
      win[WN - 1][WN - 1] <= s1_pixel;
    end
  end

  always_comb begin
    for (int r = 0; r < WN; r++) begin
      for (int c = 0; c < WN; c++) begin
        win_flat[r * WN + c] = win[r][c];
      end
    end
  end

  // centre coordinates of the window just completed
  assign col_m2     = s1_col - CW'(mf5_pkg::BORDER);
  assign s1_coord.x = (mf5_pkg::X_BITS)'(col_m2);
  assign s1_coord.y = s1_row - YB'(mf5_pkg::BORDER);

  // window stage: only complete windows go on
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= s1_valid && s1_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_coord <= s1_coord;
    end
  end

  mf5_median_sel #(
    .PIXEL_BITS(PIXEL_BITS)
  ) u_median_sel (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .in_valid (a_valid),
    .win      (win_flat),
    .in_coord (a_coord),
    .out_valid(out_valid),
    .median   (median),
    .out_coord(out_coord)
  );

  assign center_x = out_coord.x;
  assign center_y = out_coord.y;

endmodule

// ===== hdl/mf5_checker.sv =====
module mf5_checker #(
  parameter int PIXEL_BITS = mf5_pkg::DEFAULT_PIXEL_BITS
) (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic [PIXEL_BITS-1:0]         median,
  input logic [mf5_pkg::X_BITS-1:0]    center_x,
  input logic [mf5_pkg::Y_BITS-1:0]    center_y
);

  // a held-up result keeps its value
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(median) && $stable(center_x)
      && $stable(center_y))
    else $error("held result changed");

  // a held-up result stops new requests
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while result held");

  // no result centred inside the top or left border
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> center_x >= mf5_pkg::X_BITS'(mf5_pkg::BORDER)
      && center_y >= mf5_pkg::Y_BITS'(mf5_pkg::BORDER))
    else $error("result inside border");

  // nothing comes out straight after reset
  assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind median_filter_5x5_unit mf5_checker #(.PIXEL_BITS(PIXEL_BITS)) u_mf5_checker (.*);

// ===== tb/sv/median_filter_5x5_unit_tb.sv =====
`timescale 1ns / 100ps

module median_filter_5x5_unit_tb;

  localparam int PIX_BITS     = mf5_pkg::DEFAULT_PIXEL_BITS;
  localparam int LINE_LEN     = mf5_pkg::DEFAULT_MAX_WIDTH;
  localparam int CLK_HALF     = 6;
  localparam int RESET_CYCLES = 7;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_ITEMS = 1000;
  localparam int LONG_HOLD    = 300;

  typedef logic signed [PIX_BITS-1:0] pix_t;

  typedef struct packed {
    pix_t            level;
    mf5_pkg::coord_t pos;
  } median_result_t;

  typedef enum int {PIX_FULL, PIX_TIES, PIX_EXTREME, PIX_MIXED} pix_kind_t;
  typedef enum int {STALL_NONE, STALL_SOME, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

  localparam pix_t PIX_MAX = {1'b0, {(PIX_BITS-1){1'b1}}};
  localparam pix_t PIX_MIN = {1'b1, {(PIX_BITS-1){1'b0}}};

  logic                         clk         = 1'b0;
  logic                         rst         = 1'b1;
  logic                         cfg_wr_en   = 1'b0;
  logic [mf5_pkg::CFG_BITS-1:0] cfg_wr_data = '0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic [PIX_BITS-1:0]          pixel       = '0;
  logic                         frame_start = 1'b0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic [PIX_BITS-1:0]          median;
  logic [mf5_pkg::X_BITS-1:0]   center_x;
  logic [mf5_pkg::Y_BITS-1:0]   center_y;

  // filter state as predicted
  pix_t                         line_mem [mf5_pkg::LINES][LINE_LEN];
  pix_t                         win_regs [mf5_pkg::WIN][mf5_pkg::WIN];
  logic [mf5_pkg::X_BITS-1:0]   next_col  = '0;
  logic [mf5_pkg::Y_BITS-1:0]   next_row  = '0;
  logic [mf5_pkg::CFG_BITS-1:0] row_width = mf5_pkg::WIDTH_RESET;
  median_result_t               medians_due [$];

  int          err_count   = 0;
  int          cycle_count = 0;
  bit          pacing      = 1'b0;
  int          burst_left  = 0;
  bit          hold_req    = 1'b0;
  int          hold_left   = 0;
  int          mode_left   = 0;
  stall_mode_t stall_mode  = STALL_NONE;

  median_filter_5x5_unit dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .pixel       (pixel),
    .frame_start (frame_start),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .median      (median),
    .center_x    (center_x),
    .center_y    (center_y)
  );

  always #(CLK_HALF) clk = ~clk;

  // give up on a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // 13th smallest of the window: the value with at most 12 below it and
  // at least 13 at or below it
  function automatic pix_t window_median();
    pix_t vals [mf5_pkg::WIN_AREA];
    int   below;
    int   not_above;
    pix_t pick;
    pick = '0;
    foreach (win_regs[r, c]) vals[r*mf5_pkg::WIN + c] = win_regs[r][c];
    for (int i = 0; i < mf5_pkg::WIN_AREA; i++) begin
      below = 0;
      not_above = 0;
      for (int j = 0; j < mf5_pkg::WIN_AREA; j++) begin
        if (vals[j] < vals[i]) below++;
        if (vals[j] <= vals[i]) not_above++;
      end
      if (below < mf5_pkg::MED_RANK && not_above >= mf5_pkg::MED_RANK) pick = vals[i];
    end
    return pick;
  endfunction

  // advance the predicted filter by one accepted request
  function automatic void predict_pixel(input pix_t pix, input logic restart);
    int             span;
    int             col;
    int             row;
    median_result_t res;
    span = (int'(row_width) > LINE_LEN) ? LINE_LEN : int'(row_width);
    if (restart) begin
      next_col = '0;
      next_row = '0;
    end
    col = int'(next_col);
    row = int'(next_row);
    // slide the window left and load the new column
    for (int r = 0; r < mf5_pkg::WIN; r++)
      for (int c = 0; c < mf5_pkg::WIN-1; c++) win_regs[r][c] = win_regs[r][c+1];
    for (int r = 0; r < mf5_pkg::LINES; r++) win_regs[r][mf5_pkg::WIN-1] = line_mem[r][col];
    win_regs[mf5_pkg::WIN-1][mf5_pkg::WIN-1] = pix;
    // drop the oldest line at this column
    for (int r = 0; r < mf5_pkg::LINES-1; r++) line_mem[r][col] = line_mem[r+1][col];
    line_mem[mf5_pkg::LINES-1][col] = pix;
    // border pixels complete no window
    if (col >= 2*mf5_pkg::BORDER && row >= 2*mf5_pkg::BORDER) begin
      res.level = window_median();
      res.pos.x = mf5_pkg::X_BITS'(col - mf5_pkg::BORDER);
      res.pos.y = mf5_pkg::Y_BITS'(row - mf5_pkg::BORDER);
      medians_due.insert(medians_due.size(), res);
    end
    if (col + 1 >= span) begin
      next_col = '0;
      next_row = mf5_pkg::Y_BITS'(row + 1);
    end else begin
      next_col = mf5_pkg::X_BITS'(col + 1);
    end
  endfunction

  function automatic pix_t random_pixel(input pix_kind_t kind);
    pix_kind_t pick;
    pick = (kind == PIX_MIXED) ? pix_kind_t'($urandom_range(0, 2)) : kind;
    case (pick)
      PIX_TIES:    return pix_t'($urandom_range(0, 8) - 4);
      PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? PIX_MAX : PIX_MIN;
      default:     return pix_t'($urandom);
    endcase
  endfunction

  // insert a random gap after a burst of requests
  task automatic pace_sender();
    if (pacing) begin
      if (burst_left == 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold one request until the block takes it
  task automatic send_pixel(input pix_t pix, input logic restart);
    in_valid    <= 1'b1;
    pixel       <= pix;
    frame_start <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_pixel(pix, restart);
    pace_sender();
  endtask

  // drain the block, then write the row width
  task automatic set_width(input int w);
    in_valid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mf5_pkg::CFG_BITS'(w);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    row_width = mf5_pkg::CFG_BITS'(w);
  endtask

  // receiver: stall on changing patterns, or hold off for a long stretch
  always @(posedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (mode_left == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      mode_left  = $urandom_range(20, 150);
    end else begin
      mode_left--;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_SOME:     out_stall <= ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: out_stall <= (mode_left % 5 < 2);
        default:        out_stall <= ($urandom_range(0, 99) < 75);
      endcase
    end
  end

  // compare each accepted median with the oldest one due
  always @(posedge clk) begin
    median_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (medians_due.size() == 0) begin
        $error("unexpected median %0d at (%0d,%0d)", $signed(median), center_x, center_y);
        err_count++;
      end else begin
        want = medians_due.pop_front();
        if (median !== want.level) begin
          $error("median: expected %0d, got %0d", want.level, $signed(median));
          err_count++;
        end
        if (center_x !== want.pos.x) begin
          $error("center_x: expected %0d, got %0d", want.pos.x, center_x);
          err_count++;
        end
        if (center_y !== want.pos.y) begin
          $error("center_y: expected %0d, got %0d", want.pos.y, center_y);
          err_count++;
        end
      end
    end
  end

  // abandoned frame, restart in mid row, then one 5x5 frame of extremes, 0 and -1
  task automatic test_border_extremes();
    pix_t corners [4];
    corners = '{PIX_MAX, PIX_MIN, pix_t'(0), pix_t'(-1)};
    set_width(mf5_pkg::WIN);
    for (int i = 0; i < 3; i++) send_pixel(random_pixel(PIX_FULL), i == 0);
    for (int i = 0; i < mf5_pkg::WIN_AREA; i++) send_pixel(corners[i % 4], i == 0);
    in_valid <= 1'b0;
  endtask

  // widths too small for any window
  task automatic test_small_widths();
    int widths [3];
    widths = '{0, 1, 4};
    foreach (widths[k]) begin
      set_width(widths[k]);
      for (int i = 0; i < 6; i++) send_pixel(random_pixel(PIX_FULL), i == 0);
    end
    in_valid <= 1'b0;
  endtask

  // mostly whole frames at random widths; some cut short, some with a stray restart
  task automatic test_random_frames();
    int        sent;
    int        w;
    int        count;
    logic      fresh;
    logic      restart;
    pix_kind_t kind;
    sent   = 0;
    pacing = 1'b1;
    w      = 7;
    set_width(w);
    fresh = 1'b1;
    while (sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        case ($urandom_range(0, 5))
          0:       w = $urandom_range(0, 4);
          1:       w = $urandom_range(13, 40);
          default: w = $urandom_range(5, 12);
        endcase
        set_width(w);
        fresh = 1'b1;
      end
      count = (w < 5) ? $urandom_range(3, 12) : w * $urandom_range(5, 9);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, count);
      kind = pix_kind_t'($urandom_range(0, 3));
      for (int i = 0; i < count; i++) begin
        // a new width always starts a new frame
        if (i == 0) restart = fresh || ($urandom_range(0, 3) != 0);
        else restart = ($urandom_range(0, 199) == 0);
        send_pixel(random_pixel(kind), restart);
      end
      fresh = 1'b0;
      sent += count;
    end
    pacing = 1'b0;
    in_valid <= 1'b0;
  endtask

  // hold off the receiver while requests keep coming
  task automatic test_backpressure();
    set_width(8);
    hold_req = 1'b1;
    for (int i = 0; i < 8*8; i++) send_pixel(random_pixel(PIX_MIXED), i == 0);
    in_valid <= 1'b0;
  endtask

  initial begin
    foreach (line_mem[r, c]) line_mem[r][c] = '0;
    foreach (win_regs[r, c]) win_regs[r][c] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_border_extremes();
    test_small_widths();
    test_random_frames();
    test_backpressure();
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
